FILE: hdl/stm_pkg.sv
// shared types and constants of the stereo timestamp pair matcher
package stm_pkg;

  localparam int TS_W   = 64;
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int LATE_W = 6;
  localparam int RAM_W  = 2 + 2 * TS_W;

  // most pairs a batch may report
  localparam logic [LATE_W-1:0] PAIR_LIMIT = 6'd32;

  typedef enum logic [1:0] {
    KIND_IMU   = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_KIND  = 3'd1;
  localparam logic [2:0] ST_REC_REV   = 3'd2;
  localparam logic [2:0] ST_ZERO_HDR  = 3'd3;
  localparam logic [2:0] ST_DUP_HDR   = 3'd4;
  localparam logic [2:0] ST_HDR_REV   = 3'd5;
  localparam logic [2:0] ST_NO_PAIRS  = 3'd6;
  localparam logic [2:0] ST_OVER      = 3'd7;

  // one finished batch handed from the loader to the pairing engine
  typedef struct packed {
    logic             bank;
    logic [2:0]       status;
    logic [CNT_W-1:0] msgs;
    logic [CNT_W-1:0] lcnt;
    logic [CNT_W-1:0] rcnt;
  } job_t;

  // pairing engine gives a buffer bank back to the loader
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

FILE: hdl/stm_in_if.sv
// message input channel
interface stm_in_if import stm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [TS_W-1:0] record_time;
  logic [TS_W-1:0] header_time;
  logic            batch_end;

  modport source(output valid, kind, record_time, header_time, batch_end, input ready);
  modport sink(input valid, kind, record_time, header_time, batch_end, output ready);
endinterface

FILE: hdl/stm_out_if.sv
// result output channel
interface stm_out_if import stm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_summary;
  logic [2:0]        status;
  logic [IDX_W-1:0]  lead_index;
  logic [IDX_W-1:0]  left_index;
  logic [IDX_W-1:0]  right_index;
  logic [TS_W-1:0]   camera_time;
  logic [TS_W-1:0]   record_gap;
  logic [CNT_W-1:0]  left_count;
  logic [CNT_W-1:0]  right_count;
  logic [TS_W-1:0]   largest_gap;
  logic [LATE_W-1:0] late_pair_count;
  logic              final_item;

  modport source(output valid, is_summary, status, lead_index, left_index, right_index,
                 camera_time, record_gap, left_count, right_count, largest_gap,
                 late_pair_count, final_item, input ready);
  modport sink(input valid, is_summary, status, lead_index, left_index, right_index,
               camera_time, record_gap, left_count, right_count, largest_gap,
               late_pair_count, final_item, output ready);
endinterface

FILE: hdl/stm_ram.sv
// generic ram, one write port, two registered read ports
module stm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_a,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_a_r;
  logic [W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: hdl/stm_front.sv
// loader: stores messages, checks order and per-camera headers, closes batches
module stm_front import stm_pkg::*; #(
  parameter int MSG_DEPTH = 64,
  localparam int IW = $clog2(MSG_DEPTH),
  localparam int AW = IW + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  stm_in_if.sink           in_ch,
  input  logic             q_full,
  input  rel_t             rel,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [RAM_W-1:0] wr_data,
  output logic             push,
  output job_t             job
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TS_W-1:0]  last_rec_r, last_rec_nxt;
  logic [2:0]       ord_err_r, ord_err_nxt;
  logic [2:0]       hdr_err_r, hdr_err_nxt;
  logic             over_r, over_nxt;
  logic [CNT_W-1:0] lcnt_r, lcnt_nxt;
  logic [CNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [TS_W-1:0]  last_lh_r, last_lh_nxt;
  logic [TS_W-1:0]  last_rh_r, last_rh_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             acc;
  logic             room;
  logic             bad_batch;

  assign in_ch.ready = !busy_r[bank_r] && !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign room        = cnt_r < CNT_W'(MSG_DEPTH);

  // message store write
  assign wr_en   = acc && room;
  assign wr_addr = {bank_r, cnt_r[IW-1:0]};
  assign wr_data = {in_ch.kind, in_ch.record_time, in_ch.header_time};

  // per-message checks
  always_comb begin
    cnt_nxt      = cnt_r;
    last_rec_nxt = last_rec_r;
    ord_err_nxt  = ord_err_r;
    hdr_err_nxt  = hdr_err_r;
    over_nxt     = over_r;
    lcnt_nxt     = lcnt_r;
    rcnt_nxt     = rcnt_r;
    last_lh_nxt  = last_lh_r;
    last_rh_nxt  = last_rh_r;
    if (acc) begin
      if (!room) begin
        over_nxt = 1'b1;
      end else begin
        if (ord_err_r == ST_OK) begin
          if (in_ch.kind == KIND_BAD) begin
            ord_err_nxt = ST_BAD_KIND;
          end else if (cnt_r != '0 && in_ch.record_time < last_rec_r) begin
            ord_err_nxt = ST_REC_REV;
          end
        end
        last_rec_nxt = in_ch.record_time;
        cnt_nxt      = cnt_r + 1'b1;
        // header walk stops at its first failure
        if (hdr_err_r == ST_OK) begin
          if (in_ch.kind == KIND_LEFT) begin
            lcnt_nxt = lcnt_r + 1'b1;
            if (in_ch.header_time == '0) begin
              hdr_err_nxt = ST_ZERO_HDR;
            end else if (last_lh_r != '0 && in_ch.header_time == last_lh_r) begin
              hdr_err_nxt = ST_DUP_HDR;
            end else if (last_lh_r != '0 && in_ch.header_time < last_lh_r) begin
              hdr_err_nxt = ST_HDR_REV;
            end else begin
              last_lh_nxt = in_ch.header_time;
            end
          end else if (in_ch.kind == KIND_RIGHT) begin
            rcnt_nxt = rcnt_r + 1'b1;
            if (in_ch.header_time == '0) begin
              hdr_err_nxt = ST_ZERO_HDR;
            end else if (last_rh_r != '0 && in_ch.header_time == last_rh_r) begin
              hdr_err_nxt = ST_DUP_HDR;
            end else if (last_rh_r != '0 && in_ch.header_time < last_rh_r) begin
              hdr_err_nxt = ST_HDR_REV;
            end else begin
              last_rh_nxt = in_ch.header_time;
            end
          end
        end
      end
    end
  end

  // batch close descriptor
  assign push      = acc && in_ch.batch_end;
  assign bad_batch = over_nxt || (ord_err_nxt != ST_OK);

  always_comb begin
    job.bank = bank_r;
    job.msgs = cnt_nxt;
    if (over_nxt) begin
      job.status = ST_OVER;
    end else if (ord_err_nxt != ST_OK) begin
      job.status = ord_err_nxt;
    end else begin
      job.status = hdr_err_nxt;
    end
    job.lcnt = bad_batch ? '0 : lcnt_nxt;
    job.rcnt = bad_batch ? '0 : rcnt_nxt;
  end

  // bank ownership
  always_comb begin
    busy_nxt = busy_r;
    bank_nxt = bank_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_nxt[bank_r] = 1'b1;
      bank_nxt         = ~bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r      <= '0;
      last_rec_r <= '0;
      ord_err_r  <= ST_OK;
      hdr_err_r  <= ST_OK;
      over_r     <= 1'b0;
      lcnt_r     <= '0;
      rcnt_r     <= '0;
      last_lh_r  <= '0;
      last_rh_r  <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      last_rec_r <= last_rec_nxt;
      ord_err_r  <= ord_err_nxt;
      hdr_err_r  <= hdr_err_nxt;
      over_r     <= over_nxt;
      lcnt_r     <= lcnt_nxt;
      rcnt_r     <= rcnt_nxt;
      last_lh_r  <= last_lh_nxt;
      last_rh_r  <= last_rh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

FILE: hdl/stm_job_fifo.sv
// two-entry queue of closed batches between loader and pairing engine
module stm_job_fifo import stm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output job_t head
);

  job_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: hdl/stm_back.sv
// pairing engine: merges left and right messages of a stored batch, emits pairs and summary
module stm_back import stm_pkg::*; #(
  parameter int MSG_DEPTH = 64,
  localparam int IW = $clog2(MSG_DEPTH),
  localparam int AW = IW + 1,
  localparam int CW = $clog2(MSG_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  job_t             q_job,
  output logic             q_pop,
  output logic [AW-1:0]    raddr_a,
  output logic [AW-1:0]    raddr_b,
  input  logic [RAM_W-1:0] rdata_a,
  input  logic [RAM_W-1:0] rdata_b,
  input  logic [TS_W-1:0]  gap_alarm,
  output rel_t             rel,
  stm_out_if.source        out_ch
);

  // a counting pass is needed only when more pairs than the limit can exist
  localparam bit NEED_CNT = MSG_DEPTH > 2 * 32 + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CNT_RD, S_CNT_EV, S_PAIR_RD, S_PAIR_EV, S_SUM_WAIT, S_SUM
  } state_t;

  state_t            state_r;
  job_t              job_r;
  logic [CW-1:0]     a_r, b_r;
  logic [LATE_W-1:0] pcnt_r;
  logic [TS_W-1:0]   lg_r;
  logic [LATE_W-1:0] late_r;
  logic [TS_W-1:0]   gap_r;
  logic              acc_r;
  logic              any_r;
  logic [2:0]        st_r;

  logic              ov_r;
  logic              is_sum_r;
  logic [2:0]        o_status_r;
  logic [IDX_W-1:0]  o_anchor_r, o_left_r, o_right_r;
  logic [TS_W-1:0]   o_ctime_r, o_gap_r, o_lg_r;
  logic [CNT_W-1:0]  o_lcnt_r, o_rcnt_r;
  logic [LATE_W-1:0] o_late_r;
  logic              o_final_r;

  logic [1:0]        ka, kb;
  logic [TS_W-1:0]   rec_a, rec_b, hdr_a, hdr_b;
  logic [CW-1:0]     lim;
  logic              walk_done, a_ok, b_ok, h_eq, h_lt, is_match, adv_a, adv_b;
  logic              brw_ab;
  logic [TS_W-1:0]   d_ab, d_ba, gap;
  logic              out_free;
  logic [CW-1:0]     anchor;
  logic              load_pair, load_sum;

  assign raddr_a = {job_r.bank, a_r[IW-1:0]};
  assign raddr_b = {job_r.bank, b_r[IW-1:0]};

  // merge step decode on the two stored entries
  always_comb begin
    ka        = rdata_a[RAM_W-1 -: 2];
    kb        = rdata_b[RAM_W-1 -: 2];
    rec_a     = rdata_a[2*TS_W-1 -: TS_W];
    rec_b     = rdata_b[2*TS_W-1 -: TS_W];
    hdr_a     = rdata_a[TS_W-1:0];
    hdr_b     = rdata_b[TS_W-1:0];
    lim       = CW'(job_r.msgs);
    walk_done = (a_r >= lim) || (b_r >= lim);
    a_ok      = ka == KIND_LEFT;
    b_ok      = kb == KIND_RIGHT;
    h_eq      = hdr_a == hdr_b;
    h_lt      = hdr_a < hdr_b;
    is_match  = a_ok && b_ok && h_eq;
    adv_a     = !a_ok || (b_ok && (h_eq || h_lt));
    adv_b     = !b_ok || (a_ok && (h_eq || !h_lt));
    {brw_ab, d_ab} = {1'b0, rec_a} - {1'b0, rec_b};
    d_ba      = rec_b - rec_a;
    gap       = brw_ab ? d_ba : d_ab;
    anchor    = (a_r < b_r) ? a_r : b_r;
  end

  assign out_free  = !ov_r || out_ch.ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign rel.valid = (state_r == S_SUM) && out_free;
  assign rel.bank  = job_r.bank;

  // output register loads
  assign load_pair = (state_r == S_PAIR_EV) && !walk_done && is_match && out_free;
  assign load_sum  = (state_r == S_SUM) && out_free;

  // output register
  assign out_ch.valid           = ov_r;
  assign out_ch.is_summary      = is_sum_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.lead_index      = o_anchor_r;
  assign out_ch.left_index      = o_left_r;
  assign out_ch.right_index     = o_right_r;
  assign out_ch.camera_time     = o_ctime_r;
  assign out_ch.record_gap      = o_gap_r;
  assign out_ch.left_count      = o_lcnt_r;
  assign out_ch.right_count     = o_rcnt_r;
  assign out_ch.largest_gap     = o_lg_r;
  assign out_ch.late_pair_count = o_late_r;
  assign out_ch.final_item      = o_final_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      acc_r   <= 1'b0;
    end else begin
      if (load_pair || load_sum) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      // running gap statistics, updated from the registered acc_r flag after each pair
      acc_r <= load_pair;
      if (acc_r) begin
        if (gap_r > lg_r) begin
          lg_r <= gap_r;
        end
        if (gap_r >= gap_alarm) begin
          late_r <= late_r + 1'b1;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            job_r  <= q_job;
            a_r    <= '0;
            b_r    <= '0;
            pcnt_r <= '0;
            lg_r   <= '0;
            late_r <= '0;
            any_r  <= 1'b0;
            st_r   <= q_job.status;
            if (q_job.status != ST_OK) begin
              state_r <= S_SUM;
            end else if (NEED_CNT) begin
              state_r <= S_CNT_RD;
            end else begin
              state_r <= S_PAIR_RD;
            end
          end
        end
        S_CNT_RD: state_r <= S_CNT_EV;
        S_CNT_EV: begin
          if (walk_done) begin
            a_r <= '0;
            b_r <= '0;
            if (pcnt_r > PAIR_LIMIT) begin
              st_r    <= ST_OVER;
              state_r <= S_SUM;
            end else begin
              state_r <= S_PAIR_RD;
            end
          end else begin
            if (adv_a) begin
              a_r <= a_r + 1'b1;
            end
            if (adv_b) begin
              b_r <= b_r + 1'b1;
            end
            if (is_match && pcnt_r <= PAIR_LIMIT) begin
              pcnt_r <= pcnt_r + 1'b1;
            end
            state_r <= S_CNT_RD;
          end
        end
        S_PAIR_RD: state_r <= S_PAIR_EV;
        S_PAIR_EV: begin
          if (walk_done) begin
            state_r <= S_SUM_WAIT;
          end else if (!is_match || out_free) begin
            if (adv_a) begin
              a_r <= a_r + 1'b1;
            end
            if (adv_b) begin
              b_r <= b_r + 1'b1;
            end
            if (is_match) begin
              is_sum_r   <= 1'b0;
              o_status_r <= ST_OK;
              o_anchor_r <= IDX_W'(anchor);
              o_left_r   <= IDX_W'(a_r);
              o_right_r  <= IDX_W'(b_r);
              o_ctime_r  <= hdr_a;
              o_gap_r    <= gap;
              o_lcnt_r   <= '0;
              o_rcnt_r   <= '0;
              o_lg_r     <= '0;
              o_late_r   <= '0;
              o_final_r  <= 1'b0;
              gap_r      <= gap;
              any_r      <= 1'b1;
            end
            state_r <= S_PAIR_RD;
          end
        end
        S_SUM_WAIT: begin
          if (!any_r) begin
            st_r <= ST_NO_PAIRS;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            is_sum_r   <= 1'b1;
            o_status_r <= st_r;
            o_anchor_r <= '0;
            o_left_r   <= '0;
            o_right_r  <= '0;
            o_ctime_r  <= '0;
            o_gap_r    <= '0;
            o_lcnt_r   <= job_r.lcnt;
            o_rcnt_r   <= job_r.rcnt;
            o_lg_r     <= (st_r == ST_OK) ? lg_r : '0;
            o_late_r   <= (st_r == ST_OK) ? late_r : '0;
            o_final_r  <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/stereo_timestamp_pair_matcher.sv
// top level of the stereo timestamp pair matcher
//
// Messages arrive on in_ch (valid/ready); a transfer with batch_end high closes a batch.
// Each message is stored and checked as it arrives, one transfer per cycle while in_ch.ready
// is high. When a batch closes, the pairing engine walks the stored batch with two read
// pointers (left and right) and sends each matched pair on out_ch, in order of the smaller
// index, then one summary with final_item high. On an error only the summary is sent.
// The merge step is bound by the registered read of the message store. With MSG_DEPTH
// above 65 a counting pass over the batch runs first. The store holds two banks, so the
// next batch loads while the previous one is paired; in_ch.ready drops only when both
// banks are in use. gap_alarm_ns is to be written through cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this. Reset (rst_n low,
// synchronous) frees both banks, empties the batch queue, clears the output valid and
// sets gap_alarm_ns to 20000000. A stall on out_ch holds the pending result in the
// output register and pauses the pairing walk.
module stereo_timestamp_pair_matcher import stm_pkg::*; #(
  parameter int MSG_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  stm_in_if.sink          in_ch,
  stm_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [TS_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(MSG_DEPTH);
  localparam int AW = IW + 1;

  logic [TS_W-1:0]  gap_alarm_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [RAM_W-1:0] wr_data;
  logic [AW-1:0]    raddr_a, raddr_b;
  logic [RAM_W-1:0] rdata_a, rdata_b;
  logic             push, pop, q_full, q_valid;
  job_t             push_job, head_job;
  rel_t             rel;

  // alarm threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_alarm_r <= 64'd20000000;
    end else if (cfg_we) begin
      gap_alarm_r <= cfg_wdata;
    end
  end

  stm_front #(.MSG_DEPTH(MSG_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .rel     (rel),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .push    (push),
    .job     (push_job)
  );

  stm_ram #(.W(RAM_W), .DEPTH(2 * (2 ** IW))) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  stm_job_fifo u_jobs (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_job)
  );

  stm_back #(.MSG_DEPTH(MSG_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (pop),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .gap_alarm (gap_alarm_r),
    .rel       (rel),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // a closed batch never finds the queue full
  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("batch queue overflow");

  // a pair's anchor is one of its two indexes
  a_anchor_member: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.is_summary |->
      (out_ch.lead_index == out_ch.left_index) ||
      (out_ch.lead_index == out_ch.right_index))
    else $error("pair anchor index mismatch");

  // only the summary closes a batch, and every pair carries status OK
  a_final_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.final_item == out_ch.is_summary) &&
      (out_ch.is_summary || out_ch.status == ST_OK))
    else $error("final flag or pair status wrong");

  // nothing is presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid) else $error("output valid after reset");
`endif

endmodule

FILE: dv/tb_top.sv
// testbench for the stereo timestamp pair matcher: batch pairing checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import stm_pkg::*;

  localparam int DEPTH      = 64;
  localparam int DRAIN_CYC  = 300;
  localparam int MAX_SHOWN  = 10;
  localparam int EXP_DEPTH  = 1024;

  typedef struct packed {
    logic              is_summary;
    logic [2:0]        status;
    logic [IDX_W-1:0]  lead_index;
    logic [IDX_W-1:0]  left_index;
    logic [IDX_W-1:0]  right_index;
    logic [TS_W-1:0]   camera_time;
    logic [TS_W-1:0]   record_gap;
    logic [CNT_W-1:0]  left_count;
    logic [CNT_W-1:0]  right_count;
    logic [TS_W-1:0]   largest_gap;
    logic [LATE_W-1:0] late_pair_count;
    logic              final_item;
  } match_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TS_W-1:0] cfg_wdata;

  stm_in_if  in_ch ();
  stm_out_if out_ch ();

  stereo_timestamp_pair_matcher #(.MSG_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the batch state
  kind_t           mdl_kind [DEPTH];
  logic [TS_W-1:0] mdl_rec  [DEPTH];
  logic [TS_W-1:0] mdl_hdr  [DEPTH];
  int              mdl_count;
  logic [TS_W-1:0] mdl_last_rec;
  logic [2:0]      mdl_order_err;
  bit              mdl_over;
  logic [TS_W-1:0] mdl_alarm;

  // expected results, written by the predictor and read by the checker
  match_res_t exp_mem [EXP_DEPTH];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  mismatch_cnt = 0;
  bit  no_idle;
  int  rx_cnt = 0;
  int  rx_seen = 0;
  int  rx_wait = 0;
  int  hold_len;
  bit  hold_go;
  bit  hold_seen = 1'b0;
  int  hold_cycles = 0;
  bit  hold_off = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // fixed run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void add_expected(match_res_t r);
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  // pairing walk of one closed batch, fills the expected results
  function automatic void close_batch();
    int lidx[DEPTH];
    int ridx[DEPTH];
    int nl, nr, a, b, n, l, r;
    logic [2:0] st;
    logic [TS_W-1:0] lg, gap, hl, hr, last_l, last_r;
    logic [LATE_W-1:0] late;
    logic [CNT_W-1:0] lc, rc;
    match_res_t pairs[DEPTH];
    match_res_t res;
    st = ST_OK; lg = '0; late = '0; lc = '0; rc = '0; last_l = '0; last_r = '0; n = 0;
    nl = 0; nr = 0;
    if (mdl_over) st = ST_OVER;
    else if (mdl_order_err != ST_OK) st = mdl_order_err;
    else begin
      // per camera header checks in index order
      for (int i = 0; i < mdl_count; i++) begin
        if (mdl_kind[i] == KIND_LEFT) begin
          lc++;
          if (mdl_hdr[i] == '0) begin st = ST_ZERO_HDR; break; end
          if (last_l != '0 && mdl_hdr[i] == last_l) begin st = ST_DUP_HDR; break; end
          if (last_l != '0 && mdl_hdr[i] < last_l) begin st = ST_HDR_REV; break; end
          last_l = mdl_hdr[i];
          lidx[nl] = i;
          nl++;
        end else if (mdl_kind[i] == KIND_RIGHT) begin
          rc++;
          if (mdl_hdr[i] == '0) begin st = ST_ZERO_HDR; break; end
          if (last_r != '0 && mdl_hdr[i] == last_r) begin st = ST_DUP_HDR; break; end
          if (last_r != '0 && mdl_hdr[i] < last_r) begin st = ST_HDR_REV; break; end
          last_r = mdl_hdr[i];
          ridx[nr] = i;
          nr++;
        end
      end
      if (st == ST_OK) begin
        // merge of the two sorted header lists
        a = 0; b = 0;
        while (a < nl && b < nr) begin
          hl = mdl_hdr[lidx[a]];
          hr = mdl_hdr[ridx[b]];
          if (hl == hr) begin
            l = lidx[a]; r = ridx[b];
            gap = (mdl_rec[l] >= mdl_rec[r]) ? mdl_rec[l] - mdl_rec[r] : mdl_rec[r] - mdl_rec[l];
            if (n >= PAIR_LIMIT) begin st = ST_OVER; break; end
            res = '0;
            res.lead_index   = (l < r) ? l[IDX_W-1:0] : r[IDX_W-1:0];
            res.left_index   = l[IDX_W-1:0];
            res.right_index  = r[IDX_W-1:0];
            res.camera_time  = hl;
            res.record_gap   = gap;
            pairs[n] = res;
            n++;
            if (gap > lg) lg = gap;
            if (gap >= mdl_alarm) late++;
            a++; b++;
          end else if (hl < hr) a++;
          else b++;
        end
        if (st == ST_OK && n == 0) st = ST_NO_PAIRS;
      end
    end
    if (st != ST_OK) begin
      n = 0;
      lg = '0; late = '0;
    end
    for (int k = 0; k < n; k++) add_expected(pairs[k]);
    res = '0;
    res.is_summary = 1'b1;
    res.status = st;
    res.left_count = lc;
    res.right_count = rc;
    res.largest_gap = lg;
    res.late_pair_count = late;
    res.final_item = 1'b1;
    add_expected(res);
    mdl_count = 0; mdl_last_rec = '0; mdl_order_err = ST_OK; mdl_over = 0;
  endfunction

  // one accepted message into the predictor
  function automatic void load_message(kind_t k, logic [TS_W-1:0] rec, logic [TS_W-1:0] hdr,
                                       logic last);
    if (mdl_count >= DEPTH) mdl_over = 1;
    else begin
      if (mdl_order_err == ST_OK) begin
        if (k == KIND_BAD) mdl_order_err = ST_BAD_KIND;
        else if (mdl_count > 0 && rec < mdl_last_rec) mdl_order_err = ST_REC_REV;
      end
      mdl_last_rec = rec;
      mdl_kind[mdl_count] = k;
      mdl_rec[mdl_count] = rec;
      mdl_hdr[mdl_count] = hdr;
      mdl_count++;
    end
    if (last) close_batch();
  endfunction

  // send one message; entered and left at a rising edge
  task automatic send_msg(kind_t k, logic [TS_W-1:0] rec, logic [TS_W-1:0] hdr, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.record_time <= rec;
    in_ch.header_time <= hdr;
    in_ch.batch_end   <= last;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    load_message(k, rec, hdr, last);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_alarm(logic [TS_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_alarm = v;
  endtask

  // result checker, sampled away from the driving edge
  always @(negedge clk) begin
    match_res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_cnt++;
      got = '{out_ch.is_summary, out_ch.status, out_ch.lead_index, out_ch.left_index,
              out_ch.right_index, out_ch.camera_time, out_ch.record_gap, out_ch.left_count,
              out_ch.right_count, out_ch.largest_gap, out_ch.late_pair_count,
              out_ch.final_item};
      if (exp_wr == exp_rd) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN) $display("unexpected result %h", got);
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got.is_summary !== want.is_summary || got.status !== want.status ||
            got.lead_index !== want.lead_index || got.left_index !== want.left_index ||
            got.right_index !== want.right_index || got.camera_time !== want.camera_time ||
            got.record_gap !== want.record_gap || got.left_count !== want.left_count ||
            got.right_count !== want.right_count || got.largest_gap !== want.largest_gap ||
            got.late_pair_count !== want.late_pair_count ||
            got.final_item !== want.final_item) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN) begin
            $display("mismatch: summ %0d/%0d st %0d/%0d anc %0d/%0d l %0d/%0d r %0d/%0d",
                     want.is_summary, got.is_summary, want.status, got.status,
                     want.lead_index, got.lead_index, want.left_index, got.left_index,
                     want.right_index, got.right_index);
            $display("  cam %h/%h gap %h/%h lc %0d/%0d rc %0d/%0d",
                     want.camera_time, got.camera_time, want.record_gap, got.record_gap,
                     want.left_count, got.left_count, want.right_count, got.right_count);
            $display("  lg %h/%h late %0d/%0d fin %0d/%0d", want.largest_gap, got.largest_gap,
                     want.late_pair_count, got.late_pair_count, want.final_item,
                     got.final_item);
          end
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen   <= hold_go;
      hold_cycles <= hold_len;
    end else if (hold_cycles > 0) begin
      hold_off <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  // receiver ready with a random wait per result
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_cnt != rx_seen) begin
        rx_seen = rx_cnt;
        rx_wait = no_idle ? 0 : $urandom_range(0, 18);
      end
      if (hold_off || rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        if (!hold_off) rx_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [TS_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // extremes, every status except ST_OVER, and the pairing corner cases
  task automatic test_directed();
    // basic pairs, gap both ways, imu in between, full-scale headers
    send_msg(KIND_LEFT,  64'd100, 64'd10, 1'b0);
    send_msg(KIND_IMU,   64'd150, 64'd0, 1'b0);
    send_msg(KIND_RIGHT, 64'd20000100, 64'd10, 1'b0);
    send_msg(KIND_RIGHT, 64'd20000200, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    send_msg(KIND_LEFT,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    // bad kind comes before a record reversal
    send_msg(KIND_LEFT, 64'd50, 64'd1, 1'b0);
    send_msg(KIND_BAD,  64'd60, 64'd1, 1'b0);
    send_msg(KIND_RIGHT, 64'd10, 64'd1, 1'b1);
    // record reversal
    send_msg(KIND_LEFT, 64'd50, 64'd1, 1'b0);
    send_msg(KIND_RIGHT, 64'd49, 64'd1, 1'b1);
    // zero header
    send_msg(KIND_RIGHT, 64'd0, 64'd0, 1'b1);
    // duplicate header on one camera
    send_msg(KIND_LEFT, 64'd1, 64'd7, 1'b0);
    send_msg(KIND_LEFT, 64'd2, 64'd7, 1'b1);
    // reversed header
    send_msg(KIND_RIGHT, 64'd1, 64'd9, 1'b0);
    send_msg(KIND_IMU,   64'd1, 64'd9, 1'b0);
    send_msg(KIND_RIGHT, 64'd3, 64'd8, 1'b1);
    // no pairs
    send_msg(KIND_LEFT, 64'd1, 64'd5, 1'b0);
    send_msg(KIND_RIGHT, 64'd2, 64'd6, 1'b1);
    // lone imu message
    send_msg(KIND_IMU, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  // threshold at its extremes and at the gap boundary
  task automatic test_alarm_levels();
    write_alarm(64'd0);
    send_msg(KIND_LEFT, 64'd5, 64'd3, 1'b0);
    send_msg(KIND_RIGHT, 64'd5, 64'd3, 1'b1);
    write_alarm(64'd30);
    send_msg(KIND_LEFT, 64'd0, 64'd3, 1'b0);
    send_msg(KIND_RIGHT, 64'd30, 64'd3, 1'b0);
    send_msg(KIND_LEFT, 64'd31, 64'd4, 1'b0);
    send_msg(KIND_RIGHT, 64'd60, 64'd4, 1'b1);
    write_alarm(64'hFFFF_FFFF_FFFF_FFFF);
    send_msg(KIND_RIGHT, 64'd0, 64'd2, 1'b0);
    send_msg(KIND_LEFT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 1'b1);
  endtask

  // more messages than the store holds
  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 2; i++)
      send_msg((i % 2) ? KIND_RIGHT : KIND_LEFT, TS_W'(i), TS_W'(i / 2 + 1),
               i == DEPTH + 1);
  endtask

  // one random batch: mostly clean streams, sometimes noise
  task automatic send_batch(int len, bit noisy);
    logic [TS_W-1:0] rec, hdr;
    int ev;
    rec = ($urandom_range(0, 3) == 0) ? rand64() >> 1 : TS_W'($urandom);
    hdr = ($urandom_range(0, 3) == 0) ? rand64() >> 1 : TS_W'($urandom_range(1, 1000));
    for (int i = 0; i < len; i++) begin
      ev = $urandom_range(0, 9);
      rec = rec + $urandom_range(0, 40000000);
      hdr = hdr + $urandom_range(1, 50);
      if (noisy && $urandom_range(0, 5) == 0)
        send_msg(kind_t'($urandom_range(0, 3)), rand64(),
                 ($urandom_range(0, 1)) ? rand64() : hdr - $urandom_range(0, 60),
                 i == len - 1);
      else if (ev < 5 && i < len - 1) begin
        // both cameras for one frame, either order
        if ($urandom_range(0, 1)) begin
          send_msg(KIND_LEFT, rec, hdr, 1'b0);
          send_msg(KIND_RIGHT, rec + $urandom_range(0, 30000000), hdr, i + 1 == len - 1);
        end else begin
          send_msg(KIND_RIGHT, rec, hdr, 1'b0);
          send_msg(KIND_LEFT, rec + $urandom_range(0, 30000000), hdr, i + 1 == len - 1);
        end
        i++;
      end else if (ev < 7) send_msg(KIND_LEFT, rec, hdr, i == len - 1);
      else if (ev < 9) send_msg(KIND_RIGHT, rec, hdr, i == len - 1);
      else send_msg(KIND_IMU, rec, rand64(), i == len - 1);
    end
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 8) begin
      int len;
      len = $urandom_range(1, 14);
      no_idle = ($urandom_range(0, 4) == 0);
      send_batch(len, $urandom_range(0, 3) == 0);
      sent += len;
      if ($urandom_range(0, 5) == 0) write_alarm(TS_W'($urandom_range(0, 40000000)));
    end
    no_idle = 0;
  endtask

  // receiver stalls long while batches keep coming
  task automatic test_backpressure();
    drain();
    no_idle = 1;
    hold_len = 600;
    hold_go = ~hold_go;
    repeat (4) send_batch(6, 0);
    no_idle = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_IMU;
    in_ch.record_time = '0;
    in_ch.header_time = '0;
    in_ch.batch_end = 1'b0;
    no_idle = 0;
    hold_len = 0;
    hold_go = 1'b0;
    mdl_count = 0; mdl_last_rec = '0; mdl_order_err = ST_OK; mdl_over = 0;
    mdl_alarm = 64'd20000000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_alarm_levels();
    test_overflow();
    write_alarm(64'd20000000);
    test_random();
    test_backpressure();

    drain();
    if (mismatch_cnt == 0 && exp_wr == exp_rd) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
